@@ src/ftt_pkg.sv @@
// ----------------------------------------------------------------------------
// ftt_pkg
// shared constants, types and the digit helper for the frame count to
// timecode text converter
// ----------------------------------------------------------------------------
package ftt_pkg;

  localparam int unsigned FRAME_RATE_DEF = 25;

  localparam int unsigned CNT_W   = 32;  // frame count / magnitude width
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned FIELD_W = 6;   // one timecode field, 0..59
  localparam int unsigned SEC_W   = 32;  // total seconds (frame rate may be 1)
  localparam int unsigned MIN_W   = 26;  // total minutes, below 2^31 / 60
  localparam int unsigned HOUR_W  = 20;  // total hours, below 2^26 / 60

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;

  localparam int unsigned TC_LEN  = 11;  // "HH:MM:SS:FF"
  localparam int unsigned MAX_LEN = 12;  // with leading minus
  localparam int unsigned LEN_W   = 4;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t DIGIT_BASE = 8'h30;
  localparam char_t SEP_CHAR   = 8'h3A;
  localparam char_t MINUS_CHAR = 8'h2D;

  // two ascii digits of a value below 64: tens via multiply by 13/128
  function automatic logic [2*CHAR_W-1:0] digit_pair(input logic [FIELD_W-1:0] v);
    logic [9:0]         p;
    logic [2:0]         t;
    logic [FIELD_W-1:0] lo;
    p  = 10'(v) * 10'd13;
    t  = p[9:7];
    lo = v - FIELD_W'(6'(t) * 6'd10);
    return {DIGIT_BASE | {5'd0, t}, DIGIT_BASE | {4'd0, lo[3:0]}};
  endfunction

endpackage

@@ src/ftt_if.sv @@
// ----------------------------------------------------------------------------
// ftt_if
// valid/ready channels: frame count requests in, characters out
// ----------------------------------------------------------------------------
interface ftt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ftt_pkg::CNT_W-1:0]    frame_count;

  modport source (output valid, output frame_count, input ready);
  modport sink   (input valid, input frame_count, output ready);
endinterface

interface ftt_out_if;
  logic                 valid;
  logic                 ready;
  ftt_pkg::char_t       char_code;
  logic                 is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ src/ftt_divc.sv @@
// ----------------------------------------------------------------------------
// ftt_divc
// two-stage divide by a constant: reciprocal multiply, then one
// correction step; carries a side payload alongside
// ----------------------------------------------------------------------------
module ftt_divc #(
  parameter int unsigned DIVISOR = 60,
  parameter int unsigned DW      = 32,
  parameter int unsigned QW      = 32,
  parameter int unsigned RW      = 6,
  parameter int unsigned SW      = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [RW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  // floor((2^32-1)/d): estimate is low by at most one for dividends up to 2^31
  localparam logic [31:0] Recip = 32'(64'hFFFF_FFFF / 64'(DIVISOR));

  logic [DW+31:0] prod;
  logic           v1_q, v2_q;
  logic [DW-1:0]  dvd_q, qe_q;
  logic [SW-1:0]  side1_q, side2_q;
  logic [DW-1:0]  back, rem_full, quot_d, rem_d;
  logic           fix;
  logic [QW-1:0]  quot_q;
  logic [RW-1:0]  rem_q;

  assign prod = (DW+32)'(dividend_i) * (DW+32)'(Recip);

  assign back     = qe_q * DW'(DIVISOR);
  assign rem_full = dvd_q - back;
  assign fix      = rem_full >= DW'(DIVISOR);
  assign quot_d   = fix ? qe_q + DW'(1) : qe_q;
  assign rem_d    = fix ? rem_full - DW'(DIVISOR) : rem_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q   <= dividend_i;
      qe_q    <= prod[DW+31:32];
      side1_q <= side_i;
      quot_q  <= quot_d[QW-1:0];
      rem_q   <= rem_d[RW-1:0];
      side2_q <= side1_q;
    end
  end

  assign valid_o = v2_q;
  assign quot_o  = quot_q;
  assign rem_o   = rem_q;
  assign side_o  = side2_q;

endmodule

@@ src/frames_to_timecode_text.sv @@
// a request is registered at the input, passes the frame, second, minute and
// hour dividers and is loaded into the character shift line; it gives 11
// characters (12 when negative) on the one-character port, and while they drain
// later requests enter the dividers, which stall while a finished one waits
// reset: asynchronous, active low; clears all valid bits and the character count
// ----------------------------------------------------------------------------
// frames_to_timecode_text
// signed frame count to ascii timecode [-]HH:MM:SS:FF, 11 or 12 chars per request
// ----------------------------------------------------------------------------
module frames_to_timecode_text #(
  parameter int unsigned FRAME_RATE = ftt_pkg::FRAME_RATE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ftt_in_if.sink     in_i,
  ftt_out_if.source  out_o
);

  localparam int unsigned FW = ftt_pkg::FIELD_W;

  logic                         en, load, deliver;
  logic [ftt_pkg::CNT_W-1:0]    raw, mag_q;
  logic                         v0_q, neg_q;

  logic                         v1, v2, v3, v4;
  logic [ftt_pkg::SEC_W-1:0]    secs;
  logic [ftt_pkg::MIN_W-1:0]    mins;
  logic [ftt_pkg::HOUR_W-1:0]   hours;
  logic [FW-1:0]                ff1, ss2, mm3, hh4;
  logic [0:0]                   side1;
  logic [FW:0]                  side2;
  logic [2*FW:0]                side3;
  logic [3*FW:0]                side4;
  logic                         neg4;
  logic [FW-1:0]                ff4, ss4, mm4;

  ftt_pkg::char_t               tc [ftt_pkg::TC_LEN];
  ftt_pkg::char_t               chars_d [ftt_pkg::MAX_LEN];
  ftt_pkg::char_t               ch_q [ftt_pkg::MAX_LEN];
  logic [ftt_pkg::LEN_W-1:0]    cnt_q;

  // pipeline advances unless the finished request waits on a busy serializer
  assign deliver = (cnt_q != '0) && out_o.ready;
  assign load    = v4 && ((cnt_q == '0) || ((cnt_q == ftt_pkg::LEN_W'(1)) && out_o.ready));
  assign en      = !v4 || load;
  assign in_i.ready = en;

  assign raw = unsigned'(in_i.frame_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q <= raw[ftt_pkg::CNT_W-1];
      mag_q <= raw[ftt_pkg::CNT_W-1] ? ('0 - raw) : raw;
    end
  end

  assign side1 = neg_q;

  ftt_divc #(
    .DIVISOR (FRAME_RATE),
    .DW      (ftt_pkg::CNT_W),
    .QW      (ftt_pkg::SEC_W),
    .RW      (FW),
    .SW      (1)
  ) u_div_frames (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v0_q),
    .dividend_i (mag_q),
    .side_i     (side1),
    .valid_o    (v1),
    .quot_o     (secs),
    .rem_o      (ff1),
    .side_o     (side2[FW])
  );

  assign side2[FW-1:0] = ff1;

  ftt_divc #(
    .DIVISOR (ftt_pkg::SECS_PER_MIN),
    .DW      (ftt_pkg::SEC_W),
    .QW      (ftt_pkg::MIN_W),
    .RW      (FW),
    .SW      (FW+1)
  ) u_div_secs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v1),
    .dividend_i (secs),
    .side_i     (side2),
    .valid_o    (v2),
    .quot_o     (mins),
    .rem_o      (ss2),
    .side_o     (side3[2*FW:FW])
  );

  assign side3[FW-1:0] = ss2;

  ftt_divc #(
    .DIVISOR (ftt_pkg::MINS_PER_HOUR),
    .DW      (ftt_pkg::MIN_W),
    .QW      (ftt_pkg::HOUR_W),
    .RW      (FW),
    .SW      (2*FW+1)
  ) u_div_mins (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v2),
    .dividend_i (mins),
    .side_i     (side3),
    .valid_o    (v3),
    .quot_o     (hours),
    .rem_o      (mm3),
    .side_o     (side4[3*FW:FW])
  );

  assign side4[FW-1:0] = mm3;

  // whole days are dropped, only the remainder is kept
  ftt_divc #(
    .DIVISOR (ftt_pkg::HOURS_PER_DAY),
    .DW      (ftt_pkg::HOUR_W),
    .QW      (1),
    .RW      (FW),
    .SW      (3*FW+1)
  ) u_div_hours (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3),
    .dividend_i (hours),
    .side_i     (side4),
    .valid_o    (v4),
    .quot_o     (),
    .rem_o      (hh4),
    .side_o     ({neg4, ff4, ss4, mm4})
  );

  always_comb begin
    {tc[0], tc[1]}  = ftt_pkg::digit_pair(hh4);
    tc[2]           = ftt_pkg::SEP_CHAR;
    {tc[3], tc[4]}  = ftt_pkg::digit_pair(mm4);
    tc[5]           = ftt_pkg::SEP_CHAR;
    {tc[6], tc[7]}  = ftt_pkg::digit_pair(ss4);
    tc[8]           = ftt_pkg::SEP_CHAR;
    {tc[9], tc[10]} = ftt_pkg::digit_pair(ff4);
    if (neg4) begin
      chars_d[0] = ftt_pkg::MINUS_CHAR;
      for (int i = 0; i < ftt_pkg::TC_LEN; i++) begin
        chars_d[i+1] = tc[i];
      end
    end else begin
      for (int i = 0; i < ftt_pkg::TC_LEN; i++) begin
        chars_d[i] = tc[i];
      end
      chars_d[ftt_pkg::MAX_LEN-1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= neg4 ? ftt_pkg::LEN_W'(ftt_pkg::MAX_LEN) : ftt_pkg::LEN_W'(ftt_pkg::TC_LEN);
    end else if (deliver) begin
      cnt_q <= cnt_q - ftt_pkg::LEN_W'(1);
    end
  end

  // shift line: the head character is always at index 0
  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q <= chars_d;
    end else if (deliver) begin
      for (int i = 0; i < ftt_pkg::MAX_LEN - 1; i++) begin
        ch_q[i] <= ch_q[i+1];
      end
      ch_q[ftt_pkg::MAX_LEN-1] <= '0;
    end
  end

  assign out_o.valid     = cnt_q != '0;
  assign out_o.char_code = ch_q[0];
  assign out_o.is_last   = cnt_q == ftt_pkg::LEN_W'(1);

endmodule

@@ test/ftt_timecode_checker.sv @@
// ----------------------------------------------------------------------------
// ftt_timecode_checker
// watches the request and character channels of the timecode converter,
// predicts the text of every taken frame count and compares it with the
// characters the block sends, one by one
// ----------------------------------------------------------------------------
module ftt_timecode_checker #(
  parameter int unsigned FRAME_RATE = ftt_pkg::FRAME_RATE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  logic [ftt_pkg::CNT_W-1:0]   req_count_i,
  input  logic                        chr_valid_i,
  input  logic                        chr_ready_i,
  input  ftt_pkg::char_t              chr_code_i,
  input  logic                        chr_last_i,
  output int                          pending_o,
  output int                          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ftt_pkg::*;

  typedef struct packed {
    char_t code;
    logic  last;
  } tc_char_t;

  tc_char_t timecode_chars[$];
  int       mismatch_count;
  int       char_index;

  function automatic void push_char(input char_t code);
    tc_char_t c;
    c.code = code;
    c.last = 1'b0;
    timecode_chars.push_back(c);
  endfunction

  function automatic void push_pair(input int unsigned v);
    push_char(DIGIT_BASE | char_t'(v / 10));
    push_char(DIGIT_BASE | char_t'(v % 10));
  endfunction

  // expected text of one frame count, appended to the queue
  function automatic void timecode_text(input logic [CNT_W-1:0] raw);
    int unsigned mag;
    int unsigned ff, ss, mm, hh;
    tc_char_t    tail;
    mag = raw;
    if (raw[CNT_W-1]) begin
      push_char(MINUS_CHAR);
      mag = 32'd0 - raw;
    end
    ff  = mag % FRAME_RATE;
    mag = mag / FRAME_RATE;
    ss  = mag % SECS_PER_MIN;
    mag = mag / SECS_PER_MIN;
    mm  = mag % MINS_PER_HOUR;
    mag = mag / MINS_PER_HOUR;
    hh  = mag % HOURS_PER_DAY;
    push_pair(hh);
    push_char(SEP_CHAR);
    push_pair(mm);
    push_char(SEP_CHAR);
    push_pair(ss);
    push_char(SEP_CHAR);
    push_pair(ff);
    tail = timecode_chars.pop_back();
    tail.last = 1'b1;
    timecode_chars.push_back(tail);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tc_char_t want;
    if (!rst_ni) begin
      timecode_chars.delete();
      mismatch_count <= 0;
      char_index     <= 0;
    end else begin
      // characters first: a request taken at this edge cannot be answered yet
      if (chr_valid_i && chr_ready_i) begin
        char_index <= char_index + 1;
        if (timecode_chars.size() == 0) begin
          $display("%0t: char %0d unexpected: expected none, got %h last=%b",
                   $realtime, char_index, chr_code_i, chr_last_i);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = timecode_chars.pop_front();
          if (chr_code_i !== want.code) begin
            $display("%0t: char %0d code: expected %h, got %h",
                     $realtime, char_index, want.code, chr_code_i);
            mismatch_count <= mismatch_count + 1;
          end else if (chr_last_i !== want.last) begin
            $display("%0t: char %0d is_last: expected %b, got %b",
                     $realtime, char_index, want.last, chr_last_i);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) timecode_text(req_count_i);
    end
  end

  assign pending_o = timecode_chars.size();
  assign errors_o  = mismatch_count;

endmodule

@@ test/frames_to_timecode_text_tb.sv @@
// ----------------------------------------------------------------------------
// frames_to_timecode_text_tb
// drives frame counts into the timecode converter and takes its characters
// under changing backpressure; a checker beside the block predicts the text
// and this top gives the verdict
// ----------------------------------------------------------------------------
module frames_to_timecode_text_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftt_pkg::*;

  localparam int unsigned FRAME_RATE    = FRAME_RATE_DEF;
  localparam int unsigned FRAMES_PER_DAY = FRAME_RATE * 86400;
  localparam int          RANDOM_COUNTS = 360;
  localparam int          CYCLE_LIMIT   = 250000;
  localparam int          DRAIN_CYCLES  = 30;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int tx_idle_pct = 28;
  int rx_idle_pct = 70;
  int cycle_count = 0;
  int pending;
  int errors;

  ftt_in_if  req_if ();
  ftt_out_if chr_if ();

  frames_to_timecode_text #(.FRAME_RATE(FRAME_RATE)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (chr_if)
  );

  ftt_timecode_checker #(.FRAME_RATE(FRAME_RATE)) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_count_i (req_if.frame_count),
    .chr_valid_i (chr_if.valid),
    .chr_ready_i (chr_if.ready),
    .chr_code_i  (chr_if.char_code),
    .chr_last_i  (chr_if.is_last),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid       = 1'b0;
    req_if.frame_count = '0;
    chr_if.ready       = 1'b0;
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    chr_if.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one request, with random idle cycles before it; called at a falling edge
  task automatic send_frame_count(input logic [CNT_W-1:0] v);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.frame_count <= v;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [CNT_W-1:0] random_frame_count();
    int unsigned pick;
    logic [CNT_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 40) begin
      v = $urandom_range(FRAMES_PER_DAY - 1);
    end else if (pick < 65) begin
      v = 32'd0 - 32'($urandom_range(FRAMES_PER_DAY));
    end else if (pick < 90) begin
      v = $urandom;
    end else begin
      // near whole days, either sign
      v = 32'($urandom_range(1000)) * FRAMES_PER_DAY + 32'($urandom_range(4)) - 32'd2;
      if ($urandom_range(1)) v = 32'd0 - v;
    end
    return v;
  endfunction

  logic [CNT_W-1:0] directed_counts[] = '{
    32'd0, 32'd1, 32'(FRAME_RATE - 1), 32'(FRAME_RATE),
    32'(FRAME_RATE * 60 - 1), 32'(FRAME_RATE * 60),
    32'(FRAME_RATE * 3600 - 1), 32'(FRAME_RATE * 3600),
    32'(FRAMES_PER_DAY - 1), 32'(FRAMES_PER_DAY), 32'(FRAMES_PER_DAY + 1),
    32'hFFFF_FFFF, 32'd0 - 32'(FRAME_RATE), 32'd0 - 32'(FRAMES_PER_DAY - 1),
    32'd0 - 32'(FRAMES_PER_DAY), 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0
  };

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_counts[i]) send_frame_count(directed_counts[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_COUNTS / 3; n++) send_frame_count(random_frame_count());
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
